// ----- rtl/lsd_radix_sort_bytes_unit_macros.svh -----
// assertion macros shared by the checker
// the enclosing module provides i_clk and i_rst_n
`ifndef LSD_RADIX_SORT_BYTES_UNIT_MACROS_SVH
`define LSD_RADIX_SORT_BYTES_UNIT_MACROS_SVH

// same-cycle implication
`define LRSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lrsb_pkg.sv -----
`default_nettype none

package lrsb_pkg;

    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 8;
    localparam int RADIX   = 256;
    localparam int PASS_W  = 2;
    localparam int NPASS_W = 3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_item;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               last_out;
    } t_out;

    // number of significant bytes of a value, 0 to 4
    function automatic logic [NPASS_W-1:0] byte_len(input logic [VALUE_W-1:0] v);
        logic [NPASS_W-1:0] n;
        if (v[30:24] != 7'd0) begin
            n = 3'd4;
        end else if (v[23:16] != 8'd0) begin
            n = 3'd3;
        end else if (v[15:8] != 8'd0) begin
            n = 3'd2;
        end else if (v[7:0] != 8'd0) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    // byte selected by the pass number
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [VALUE_W-1:0] v,
                                                    input logic [PASS_W-1:0]  pass);
        logic [DIGIT_W-1:0] d;
        case (pass)
            2'd0:    d = v[7:0];
            2'd1:    d = v[15:8];
            2'd2:    d = v[23:16];
            default: d = {1'b0, v[30:24]};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lrsb_ram.sv -----
`default_nettype none

// simple dual-port ram, registered read-first output
module lrsb_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/lsd_radix_sort_bytes_unit.sv -----
`default_nettype none

// Byte-wise LSD radix sorter. Values enter one per transaction at one per cycle and
// are written into bank A while their maximum is tracked; up to MAX_ITEMS are kept
// and later ones are dropped. The transaction marked last_item (stored or dropped)
// starts the sort and o_ready stays low until the whole sorted set has been taken.
// The sort runs one pass per significant byte of the maximum (0 to 4 passes). Each
// pass clears the 256-entry count table, histograms the byte, forms the prefix sum
// and scatters the values from last to first into the other bank. All of these go
// through the single read and single write port of the count table, which is what
// sets the pass length. Results then leave at one per cycle whenever the consumer
// is ready, ascending, with last_out on the final one; the block then returns to
// loading an empty set.
module lsd_radix_sort_bytes_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lrsb_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lrsb_pkg::t_out     o_data
);

    localparam int CW     = $clog2(MAX_ITEMS + 1);   // item counts 0..MAX_ITEMS
    localparam int AW     = $clog2(MAX_ITEMS);       // bank address
    localparam int VW     = lrsb_pkg::VALUE_W;
    localparam int DW     = lrsb_pkg::DIGIT_W;
    localparam int CIDX_W = lrsb_pkg::DIGIT_W + 1;   // sweeps 0..RADIX

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLEAR,
        S_HIST,
        S_PREFIX,
        S_SCATTER,
        S_OUT
    } t_state;

    t_state r_state;

    // set bookkeeping
    logic [CW-1:0]  r_count;
    logic [VW-1:0]  r_max;
    logic [lrsb_pkg::NPASS_W-1:0] r_npass;
    logic [lrsb_pkg::PASS_W-1:0]  r_pass;

    // histogram / scatter pipeline: issue, bank data, count data
    logic [CW-1:0]  r_idx;
    logic           r_s1_v;
    logic           r_s2_v;
    logic [DW-1:0]  r_s2_digit;
    logic [VW-1:0]  r_s2_value;
    logic           r_wr_v;
    logic [DW-1:0]  r_wr_digit;
    logic [CW-1:0]  r_wr_data;

    // clear / prefix sweep
    logic [CIDX_W-1:0] r_cidx;
    logic              r_pf_v;
    logic [DW-1:0]     r_pf_addr;
    logic [CW-1:0]     r_acc;

    // output side
    logic           r_out_valid;
    logic           r_out_last;
    logic [CW-1:0]  r_out_idx;

    // ram ports
    logic           w_a_we, w_a_re, w_b_we, w_b_re, w_c_we, w_c_re;
    logic [AW-1:0]  w_a_waddr, w_a_raddr, w_b_waddr, w_b_raddr;
    logic [VW-1:0]  w_a_wdata, w_b_wdata, w_a_rdata, w_b_rdata;
    logic [DW-1:0]  w_c_waddr, w_c_raddr;
    logic [CW-1:0]  w_c_wdata, w_c_rdata;

    logic           w_in_acc;
    logic           w_has_room;
    logic [VW-1:0]  w_max_new;
    logic [lrsb_pkg::NPASS_W-1:0] w_npass_new;
    logic [CW-1:0]  w_idx_m1;
    logic           w_issue;
    logic [VW-1:0]  w_src_rdata;
    logic [DW-1:0]  w_s1_digit;
    logic [CW-1:0]  w_cnt_cur;
    logic [CW-1:0]  w_cnt_new;
    logic           w_pipe_done;
    logic           w_last_pass;
    logic           w_out_adv;
    logic           w_out_more;

    assign o_ready    = (r_state == S_LOAD);
    assign w_in_acc   = i_valid && o_ready;
    assign w_has_room = (r_count < CW'(MAX_ITEMS));

    // maximum including the current value, when it is stored
    assign w_max_new   = (w_has_room && (i_data.value > r_max)) ? i_data.value : r_max;
    assign w_npass_new = lrsb_pkg::byte_len(w_max_new);

    // even passes read bank a and write bank b, odd passes the other way
    assign w_src_rdata = r_pass[0] ? w_b_rdata : w_a_rdata;
    assign w_s1_digit  = lrsb_pkg::digit_of(w_src_rdata, r_pass);
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_issue     = (r_idx != '0);

    // count written last cycle is not yet visible at the ram output
    assign w_cnt_cur = (r_wr_v && (r_wr_digit == r_s2_digit)) ? r_wr_data : w_c_rdata;
    assign w_cnt_new = (r_state == S_HIST) ? (w_cnt_cur + CW'(1)) : (w_cnt_cur - CW'(1));

    assign w_pipe_done = !w_issue && !r_s1_v && !r_s2_v;
    assign w_last_pass = (({1'b0, r_pass} + 3'd1) == r_npass);

    assign w_out_adv  = !r_out_valid || i_ready;
    assign w_out_more = (r_out_idx != r_count);

    // memory port steering
    always_comb begin
        w_a_we    = 1'b0;
        w_a_waddr = '0;
        w_a_wdata = '0;
        w_a_re    = 1'b0;
        w_a_raddr = '0;
        w_b_we    = 1'b0;
        w_b_waddr = '0;
        w_b_wdata = '0;
        w_b_re    = 1'b0;
        w_b_raddr = '0;
        w_c_we    = 1'b0;
        w_c_waddr = '0;
        w_c_wdata = '0;
        w_c_re    = 1'b0;
        w_c_raddr = '0;
        unique case (r_state)
            S_LOAD: begin
                w_a_we    = w_in_acc && w_has_room;
                w_a_waddr = r_count[AW-1:0];
                w_a_wdata = i_data.value;
            end
            S_CLEAR: begin
                w_c_we    = 1'b1;
                w_c_waddr = r_cidx[DW-1:0];
            end
            S_HIST, S_SCATTER: begin
                // stage 0: fetch the value, walking from last to first
                if (r_pass[0]) begin
                    w_b_re    = w_issue;
                    w_b_raddr = w_idx_m1[AW-1:0];
                end else begin
                    w_a_re    = w_issue;
                    w_a_raddr = w_idx_m1[AW-1:0];
                end
                // stage 1: fetch the count of its digit
                w_c_re    = r_s1_v;
                w_c_raddr = w_s1_digit;
                // stage 2: update the count, and place the value when scattering
                w_c_we    = r_s2_v;
                w_c_waddr = r_s2_digit;
                w_c_wdata = w_cnt_new;
                if (r_state == S_SCATTER) begin
                    if (r_pass[0]) begin
                        w_a_we    = r_s2_v;
                        w_a_waddr = w_cnt_new[AW-1:0];
                        w_a_wdata = r_s2_value;
                    end else begin
                        w_b_we    = r_s2_v;
                        w_b_waddr = w_cnt_new[AW-1:0];
                        w_b_wdata = r_s2_value;
                    end
                end
            end
            S_PREFIX: begin
                w_c_re    = (r_cidx != CIDX_W'(lrsb_pkg::RADIX));
                w_c_raddr = r_cidx[DW-1:0];
                w_c_we    = r_pf_v;
                w_c_waddr = r_pf_addr;
                w_c_wdata = r_acc + w_c_rdata;
            end
            S_OUT: begin
                // the bank output register holds the value on offer
                if (r_npass[0]) begin
                    w_b_re    = w_out_adv && w_out_more;
                    w_b_raddr = r_out_idx[AW-1:0];
                end else begin
                    w_a_re    = w_out_adv && w_out_more;
                    w_a_raddr = r_out_idx[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_max       <= '0;
            r_npass     <= '0;
            r_pass      <= '0;
            r_idx       <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_wr_v      <= 1'b0;
            r_cidx      <= '0;
            r_pf_v      <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_has_room) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_max <= w_max_new;
                        if (i_data.last_item) begin
                            r_npass   <= w_npass_new;
                            r_pass    <= '0;
                            r_cidx    <= '0;
                            r_out_idx <= '0;
                            if (w_npass_new == '0) begin
                                // all zero: emit as loaded
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_CLEAR;
                            end
                        end
                    end
                end
                S_CLEAR: begin
                    r_cidx <= r_cidx + CIDX_W'(1);
                    if (r_cidx == CIDX_W'(lrsb_pkg::RADIX - 1)) begin
                        r_idx   <= r_count;
                        r_s1_v  <= 1'b0;
                        r_s2_v  <= 1'b0;
                        r_wr_v  <= 1'b0;
                        r_state <= S_HIST;
                    end
                end
                S_HIST, S_SCATTER: begin
                    if (w_issue) begin
                        r_idx <= w_idx_m1;
                    end
                    r_s1_v     <= w_issue;
                    r_s2_v     <= r_s1_v;
                    r_s2_digit <= w_s1_digit;
                    r_s2_value <= w_src_rdata;
                    r_wr_v     <= r_s2_v;
                    r_wr_digit <= r_s2_digit;
                    r_wr_data  <= w_cnt_new;
                    if (w_pipe_done) begin
                        r_cidx <= '0;
                        if (r_state == S_HIST) begin
                            r_acc   <= '0;
                            r_pf_v  <= 1'b0;
                            r_state <= S_PREFIX;
                        end else if (w_last_pass) begin
                            r_out_idx <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_pass  <= r_pass + lrsb_pkg::PASS_W'(1);
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_PREFIX: begin
                    if (r_cidx != CIDX_W'(lrsb_pkg::RADIX)) begin
                        r_cidx    <= r_cidx + CIDX_W'(1);
                        r_pf_v    <= 1'b1;
                        r_pf_addr <= r_cidx[DW-1:0];
                    end else begin
                        r_pf_v <= 1'b0;
                    end
                    if (r_pf_v) begin
                        r_acc <= r_acc + w_c_rdata;
                    end
                    if ((r_cidx == CIDX_W'(lrsb_pkg::RADIX)) && !r_pf_v) begin
                        r_idx   <= r_count;
                        r_s1_v  <= 1'b0;
                        r_s2_v  <= 1'b0;
                        r_wr_v  <= 1'b0;
                        r_state <= S_SCATTER;
                    end
                end
                S_OUT: begin
                    if (w_out_adv) begin
                        if (w_out_more) begin
                            r_out_valid <= 1'b1;
                            r_out_last  <= (r_out_idx == (r_count - CW'(1)));
                            r_out_idx   <= r_out_idx + CW'(1);
                        end else begin
                            // set drained: start a fresh one
                            r_out_valid <= 1'b0;
                            r_out_last  <= 1'b0;
                            r_count     <= '0;
                            r_max       <= '0;
                            r_state     <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_data.sorted_value = r_npass[0] ? w_b_rdata : w_a_rdata;
    assign o_data.last_out     = r_out_last;

    lrsb_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_a_wdata),
        .i_re    (w_a_re),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    lrsb_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_re    (w_b_re),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    lrsb_ram #(
        .WIDTH (CW),
        .DEPTH (lrsb_pkg::RADIX)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_re    (w_c_re),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/lrsb_checker.sv -----
`default_nettype none

`include "lsd_radix_sort_bytes_unit_macros.svh"

module lrsb_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_ready,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire lrsb_pkg::t_out i_out_data
);

    logic w_stall;
    logic w_last_taken;

    assign w_stall      = i_out_valid && !i_out_ready;
    assign w_last_taken = i_out_valid && i_out_ready && i_out_data.last_out;

    // a stalled result stays offered
    `LRSB_ASSERT_NEXT(a_out_hold, w_stall, i_out_valid, "result dropped while stalled")

    // and unchanged
    `LRSB_ASSERT_NEXT(a_out_stable, w_stall, $stable(i_out_data), "stalled result changed")

    // loading and emitting never overlap
    `LRSB_ASSERT_NOW(a_no_overlap, i_out_valid, !i_in_ready, "input open while emitting")

    // nothing follows the final result of a set
    `LRSB_ASSERT_NEXT(a_last_ends, w_last_taken, !i_out_valid, "result after last_out")

endmodule

bind lsd_radix_sort_bytes_unit lrsb_checker u_lrsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);

`default_nettype wire
